// ----- src/sha256_hash_engine_assert.svh -----
// Assertion macros for the hash engine checker
`ifndef SHA256_HASH_ENGINE_ASSERT_SVH
`define SHA256_HASH_ENGINE_ASSERT_SVH

// Assert an implication on every clock edge outside reset
`define SHA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Assert a next-cycle implication outside reset
`define SHA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/sha_pkg.sv -----
package sha_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [31:0] word;
    logic        last_block;
  } blk_word_t;

  typedef enum logic [1:0] {
    BeIdle,
    BeLoad,
    BeRound,
    BeEmit
  } be_state_e;

  typedef enum logic [1:0] {
    FeData,
    FeFill,
    FeLenHi,
    FeLenLo
  } fe_state_e;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] PadByte = 32'h80;

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] v);
    ssig0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] v);
    ssig1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] v);
    bsig0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] v);
    bsig1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

endpackage

// ----- src/sha_front.sv -----
// Front end: takes message words, appends padding and length, and
// pushes block words into the queue.
module sha_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [31:0]           data_word_i,
  input  logic [2:0]            valid_bytes_i,
  input  logic                  is_last_i,
  output logic                  push_o,
  output sha_pkg::blk_word_t    push_word_o,
  input  logic                  full_i
);

  sha_pkg::fe_state_e state_q, state_d;
  logic [63:0] len_q, len_d;
  logic [3:0]  pos_q, pos_d;
  logic        extra_q, extra_d;
  logic [2:0]  nb;
  logic [31:0] keep, padded;
  logic        fire;

  // Clamp byte count and build the padded final word
  always_comb begin
    nb = (valid_bytes_i > 3'd4) ? 3'd4 : valid_bytes_i;
    case (nb)
      3'd0:    keep = 32'h0;
      3'd1:    keep = 32'hff000000;
      3'd2:    keep = 32'hffff0000;
      3'd3:    keep = 32'hffffff00;
      default: keep = 32'hffffffff;
    endcase
    padded = (data_word_i & keep) |
             ((nb == 3'd4) ? 32'h0 : (sha_pkg::PadByte << (5'd24 - {nb[1:0], 3'b000})));
  end

  assign ready_o = (state_q == sha_pkg::FeData) && !full_i;
  assign fire    = valid_i && ready_o;

  // Next state and pushed word
  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    pos_d   = pos_q;
    extra_d = extra_q;
    push_o  = 1'b0;
    push_word_o.word       = 32'h0;
    push_word_o.last_block = 1'b0;
    unique case (state_q)
      sha_pkg::FeData: begin
        if (fire) begin
          push_o = 1'b1;
          pos_d  = pos_q + 4'd1;
          if (!is_last_i) begin
            push_word_o.word = data_word_i;
            len_d = len_q + 64'd32;
          end else begin
            len_d = len_q + {58'd0, nb, 3'b000};
            if (nb == 3'd4) begin
              push_word_o.word = data_word_i;
              extra_d = 1'b1;
              state_d = sha_pkg::FeFill;
            end else begin
              push_word_o.word = padded;
              state_d = (pos_q == 4'd13) ? sha_pkg::FeLenHi : sha_pkg::FeFill;
            end
          end
        end
      end
      sha_pkg::FeFill: begin
        if (!full_i) begin
          push_o  = 1'b1;
          push_word_o.word = extra_q ? 32'h80000000 : 32'h0;
          extra_d = 1'b0;
          pos_d   = pos_q + 4'd1;
          if (pos_q == 4'd13) state_d = sha_pkg::FeLenHi;
        end
      end
      sha_pkg::FeLenHi: begin
        if (!full_i) begin
          push_o = 1'b1;
          push_word_o.word = len_q[63:32];
          pos_d   = pos_q + 4'd1;
          state_d = sha_pkg::FeLenLo;
        end
      end
      sha_pkg::FeLenLo: begin
        if (!full_i) begin
          push_o = 1'b1;
          push_word_o.word = len_q[31:0];
          push_word_o.last_block = 1'b1;
          pos_d   = 4'd0;
          len_d   = 64'd0;
          state_d = sha_pkg::FeData;
        end
      end
      default: state_d = sha_pkg::FeData;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha_pkg::FeData;
      len_q   <= 64'd0;
      pos_q   <= 4'd0;
      extra_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      extra_q <= extra_d;
    end
  end

endmodule

// ----- src/sha_queue.sv -----
// Small FIFO between front end and compression core
module sha_queue #(
  parameter int unsigned Depth = sha_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sha_pkg::blk_word_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output sha_pkg::blk_word_t pop_data_o,
  output logic               empty_o
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  sha_pkg::blk_word_t mem_q [Depth];
  logic [Aw-1:0] wr_q, rd_q;
  logic [Aw:0]   cnt_q;

  assign full_o     = (cnt_q == (Aw+1)'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  // Store on push
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + Aw'(1);
      if (pop_i)  rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + Aw'(1);
      cnt_q <= cnt_q + (Aw+1)'(push_i) - (Aw+1)'(pop_i);
    end
  end

endmodule

// ----- src/sha_core.sv -----
// Compression core: gathers 16 words, runs 64 rounds, emits the digest
module sha_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  sha_pkg::blk_word_t pop_data_i,
  output logic               pop_o,
  output logic               valid_o,
  input  logic               ready_i,
  output logic [31:0]        digest_word_o,
  output logic [2:0]         word_index_o,
  output logic               is_final_word_o
);

  sha_pkg::be_state_e state_q, state_d;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];
  logic [5:0]  rnd_q;
  logic [3:0]  cnt_q;
  logic [2:0]  idx_q;
  logic        last_q;
  logic [31:0] w_new, t1, t2;
  logic        load_done, rnd_done;

  assign pop_o     = (state_q == sha_pkg::BeLoad) && !empty_i;
  assign load_done = pop_o && (cnt_q == 4'd15);
  assign rnd_done  = (state_q == sha_pkg::BeRound) && (rnd_q == 6'd63);

  // Round datapath: schedule word w_q[0] is the current word
  always_comb begin
    w_new = sha_pkg::ssig1(w_q[14]) + w_q[9] + sha_pkg::ssig0(w_q[1]) + w_q[0];
    t1 = v_q[7] + sha_pkg::bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) +
         sha_pkg::RoundK[rnd_q] + w_q[0];
    t2 = sha_pkg::bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sha_pkg::BeIdle:  state_d = sha_pkg::BeLoad;
      sha_pkg::BeLoad:  if (load_done) state_d = sha_pkg::BeRound;
      sha_pkg::BeRound: if (rnd_done) state_d = last_q ? sha_pkg::BeEmit : sha_pkg::BeLoad;
      sha_pkg::BeEmit:  if (ready_i && idx_q == 3'd7) state_d = sha_pkg::BeLoad;
      default:          state_d = sha_pkg::BeLoad;
    endcase
  end

  // Outputs
  always_comb begin
    valid_o         = (state_q == sha_pkg::BeEmit);
    digest_word_o   = h_q[idx_q];
    word_index_o    = idx_q;
    is_final_word_o = (idx_q == 3'd7);
  end

  // Schedule and working variables
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= pop_data_i.word;
      if (load_done) for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (state_q == sha_pkg::BeRound) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
      for (int i = 1; i < 8; i++) v_q[i] <= v_q[i-1];
      v_q[4] <= v_q[3] + t1;
      v_q[0] <= t1 + t2;
    end
  end

  // Control, hash and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha_pkg::BeIdle;
      rnd_q   <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
      last_q  <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitHash[i];
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        cnt_q <= cnt_q + 4'd1;
        if (load_done) last_q <= pop_data_i.last_block;
      end
      if (state_q == sha_pkg::BeRound) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_done) begin
          h_q[0] <= h_q[0] + t1 + t2;
          h_q[1] <= h_q[1] + v_q[0];
          h_q[2] <= h_q[2] + v_q[1];
          h_q[3] <= h_q[3] + v_q[2];
          h_q[4] <= h_q[4] + v_q[3] + t1;
          h_q[5] <= h_q[5] + v_q[4];
          h_q[6] <= h_q[6] + v_q[5];
          h_q[7] <= h_q[7] + v_q[6];
        end
      end
      if (state_q == sha_pkg::BeEmit && ready_i) begin
        idx_q <= idx_q + 3'd1;
        if (idx_q == 3'd7) for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::InitHash[i];
      end
    end
  end

endmodule

// ----- src/sha256_hash_engine.sv -----
// Channel   Handshake          Payload
// input     valid_i/ready_o    data_word_i, valid_bytes_i, is_last_i
// output    valid_o/ready_i    digest_word_o, word_index_o, is_final_word_o
//
// A block is loaded as 16 words and then runs 64 rounds in the single-round unit;
// the core pops no block words while its rounds run, so the queue fills meanwhile.
// Padding completes the current block, plus one more block when the length
// does not fit; the digest takes 8 transfers.
// Reset loads the initial hash; the front end stalls on a full queue,
// the core stalls on an empty queue or an untaken digest word.
module sha256_hash_engine #(
  parameter int unsigned QueueDepth = sha_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  valid_bytes_i,
  input  logic        is_last_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        is_final_word_o
);

  logic push, full, pop, empty;
  sha_pkg::blk_word_t push_word, pop_word;

  sha_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .data_word_i, .valid_bytes_i, .is_last_i,
    .push_o(push), .push_word_o(push_word), .full_i(full)
  );

  sha_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_word), .full_o(full),
    .pop_i(pop), .pop_data_o(pop_word), .empty_o(empty)
  );

  sha_core u_core (
    .clk_i, .rst_ni, .empty_i(empty), .pop_data_i(pop_word), .pop_o(pop),
    .valid_o, .ready_i, .digest_word_o, .word_index_o, .is_final_word_o
  );

endmodule

// ----- src/sha_checker.sv -----
`include "sha256_hash_engine_assert.svh"

// Port-level checks on the digest channel
module sha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_o,
  input logic        ready_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        is_final_word_o
);

  `SHA_ASSERT_IMPL(a_final_idx, clk_i, rst_ni, valid_o, is_final_word_o == (word_index_o == 3'd7))
  `SHA_ASSERT_NEXT(a_idx_step, clk_i, rst_ni, valid_o && ready_i && !is_final_word_o, valid_o && word_index_o == $past(word_index_o) + 3'd1)
  `SHA_ASSERT_NEXT(a_hold, clk_i, rst_ni, valid_o && !ready_i, valid_o && $stable(digest_word_o))

endmodule

bind sha256_hash_engine sha_checker u_sha_checker (.*);

// ----- verif/tb_top.sv -----
module tb_top;

  typedef struct {
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        last;
  } msg_word_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        fin;
  } digest_t;

  logic        clk;
  logic        rst_n;
  logic        valid_in;
  logic        ready_out;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        is_last;
  logic        valid_out;
  logic        ready_in;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        is_final_word;

  sha256_hash_engine u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .valid_i        (valid_in),
    .ready_o        (ready_out),
    .data_word_i    (data_word),
    .valid_bytes_i  (valid_bytes),
    .is_last_i      (is_last),
    .valid_o        (valid_out),
    .ready_i        (ready_in),
    .digest_word_o  (digest_word),
    .word_index_o   (word_index),
    .is_final_word_o(is_final_word)
  );

  msg_word_t   pending_q[$];
  digest_t     digest_q[$];
  int          errors = 0;
  bit          stim_done = 0;
  bit          calm = 0;
  int          hold_off = 400;

  // Hash state of the predictor
  logic [31:0] run_hash[8];
  logic [31:0] blk[16];
  logic [63:0] msg_bits;
  int          blk_pos;

  function automatic logic [31:0] ror(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] v[8];
    logic [31:0] w[64];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++) begin
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = run_hash[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha_pkg::RoundK[t] + w[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) run_hash[i] += v[i];
  endtask

  task automatic push_block_word(logic [31:0] w);
    blk[blk_pos] = w;
    blk_pos = (blk_pos + 1) % 16;
    if (blk_pos == 0) compress();
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) run_hash[i] = sha_pkg::InitHash[i];
    msg_bits = '0;
    blk_pos = 0;
  endtask

  // Advance the hash by one accepted word; queue the digest on the last one
  task automatic hash_word(msg_word_t m);
    int n;
    logic [31:0] keep;
    digest_t d;
    if (!m.last) begin
      msg_bits += 32;
      push_block_word(m.data);
      return;
    end
    n = (m.nbytes > 4) ? 4 : m.nbytes;
    msg_bits += 64'(n * 8);
    if (n == 4) begin
      push_block_word(m.data);
      push_block_word(32'h8000_0000);
    end else begin
      keep = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
      push_block_word((m.data & keep) | (sha_pkg::PadByte << (24 - 8 * n)));
    end
    while (blk_pos != 14) push_block_word(32'h0);
    push_block_word(msg_bits[63:32]);
    push_block_word(msg_bits[31:0]);
    for (int k = 0; k < 8; k++) begin
      d.word = run_hash[k];
      d.idx  = 3'(k);
      d.fin  = (k == 7);
      digest_q.push_back(d);
    end
    restart_hash();
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver: offer queued words, idle in random bursts
  int gap = 0;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      valid_in    <= 0;
      data_word   <= '0;
      valid_bytes <= '0;
      is_last     <= 0;
    end else begin
      msg_word_t m;
      bit take;
      take = valid_in && ready_out;
      if (take) void'(pending_q.pop_front());
      if (valid_in && !take) begin
        // hold payload
      end else if (gap > 0) begin
        gap <= gap - 1;
        valid_in <= 0;
      end else if (pending_q.size() > 0 && !calm && $urandom_range(0, 9) == 0) begin
        gap <= $urandom_range(1, 17);
        valid_in <= 0;
      end else if (pending_q.size() > 0) begin
        m = pending_q[0];
        valid_in    <= 1;
        data_word   <= m.data;
        valid_bytes <= m.nbytes;
        is_last     <= m.last;
      end else begin
        valid_in <= 0;
      end
    end
  end

  // Predict on each accepted word
  always @(posedge clk) begin
    if (rst_n && valid_in && ready_out) begin
      msg_word_t m;
      m.data = data_word;
      m.nbytes = valid_bytes;
      m.last = is_last;
      hash_word(m);
    end
  end

  // Count down the long hold-off that starts right after reset
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_off <= 400;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // Receiver stall: random bursts plus one long hold-off
  int stall = 0;
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      ready_in <= 0;
    end else if (hold_off > 0) begin
      ready_in <= 0;
    end else if (stall > 0) begin
      stall <= stall - 1;
      ready_in <= 0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall <= $urandom_range(1, 17);
      ready_in <= 0;
    end else begin
      ready_in <= 1;
    end
  end

  // Monitor: compare each digest transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && valid_out && ready_in) begin
      digest_t d;
      if (digest_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected digest word %h idx %0d", $time, digest_word, word_index);
      end else begin
        d = digest_q.pop_front();
        if (digest_word !== d.word) begin
          errors++;
          $display("%0t: digest_word expected %h actual %h", $time, d.word, digest_word);
        end
        if (word_index !== d.idx) begin
          errors++;
          $display("%0t: word_index expected %0d actual %0d", $time, d.idx, word_index);
        end
        if (is_final_word !== d.fin) begin
          errors++;
          $display("%0t: is_final_word expected %0d actual %0d", $time, d.fin,
                   is_final_word);
        end
      end
    end
  end

  task automatic add_word(logic [31:0] d, logic [2:0] nb, logic last);
    msg_word_t m;
    m.data = d;
    m.nbytes = nb;
    m.last = last;
    pending_q.push_back(m);
  endtask

  // Queue a message of full words closed by a last word
  task automatic add_message(int nfull, logic [2:0] nb);
    for (int i = 0; i < nfull; i++) add_word($urandom, 3'($urandom), 0);
    add_word($urandom, nb, 1);
  endtask

  initial begin
    int sent;
    restart_hash();
    rst_n = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;

    // Directed: empty message, all byte counts, oversized counts, extremes
    add_word(32'h0, 3'd0, 1);
    add_word(32'hffff_ffff, 3'd1, 1);
    add_word(32'h0, 3'd2, 1);
    add_word(32'hffff_ffff, 3'd3, 1);
    add_word(32'h6162_6380, 3'd4, 1);
    add_word(32'hffff_ffff, 3'd7, 1);
    add_word(32'h1234_5678, 3'd5, 1);
    add_word(32'hffff_ffff, 3'd0, 0);
    add_word(32'hffff_ffff, 3'd6, 1);
    // Exact block multiple, and a length that just fits the current block
    add_message(15, 3'd4);
    add_message(13, 3'd2);

    // Long message spanning several blocks
    add_message(40, 3'd3);

    sent = pending_q.size();
    while (sent < 470) begin
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 20);
      add_message(n, 3'($urandom_range(0, 7)));
      sent += n + 1;
    end

    wait (pending_q.size() < 60);
    calm = 1;
    wait (pending_q.size() == 0 && !valid_in);
    wait (digest_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_top failed");
    $finish;
  end

endmodule
